FILE: src/h264fua_pkg.sv
package h264fua_pkg;

    localparam int unsigned FRAME_LENGTH_BITS_DEF = 20;

    // RTP / FU-A framing constants
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [10:0] RTP_HDR_BYTES    = 11'd12;
    localparam logic [10:0] FU_BYTES         = 11'd2;
    localparam logic [4:0]  FU_A_TYPE        = 5'd28;
    localparam logic [7:0]  FU_START_BIT     = 8'h80;
    localparam logic [7:0]  FU_END_BIT       = 8'h40;
    localparam logic [7:0]  FU_KEEP_MASK     = 8'h7F;

    localparam logic [10:0] MAX_PAYLOAD_MIN  = 11'd16;
    localparam logic [10:0] MAX_PAYLOAD_MAX  = 11'd1460;

    localparam logic [31:0] SSRC_RST         = 32'd0;
    localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
    localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1400;

    // configuration register indexes
    localparam logic [1:0]  CFG_SSRC         = 2'd0;
    localparam logic [1:0]  CFG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0]  CFG_MAX_PAYLOAD  = 2'd2;

    // output byte slots of one run: RTP header, FU bytes, payload byte
    typedef enum logic [3:0] {
        SLOT_VERSION = 4'd0,
        SLOT_MARK_PT = 4'd1,
        SLOT_SEQ_HI  = 4'd2,
        SLOT_SEQ_LO  = 4'd3,
        SLOT_TS_3    = 4'd4,
        SLOT_TS_2    = 4'd5,
        SLOT_TS_1    = 4'd6,
        SLOT_TS_0    = 4'd7,
        SLOT_SSRC_3  = 4'd8,
        SLOT_SSRC_2  = 4'd9,
        SLOT_SSRC_1  = 4'd10,
        SLOT_SSRC_0  = 4'd11,
        SLOT_FU_IND  = 4'd12,
        SLOT_FU_HDR  = 4'd13,
        SLOT_PAYLOAD = 4'd14
    } t_slot;

endpackage

FILE: src/h264_rtp_fua_packetizer.sv
// Channel    | Handshake               | Payload
// -----------+-------------------------+---------------------------------------------
// NAL in     | i_valid / o_stall       | i_data_byte, i_first_of_frame,
//            |                         | i_frame_length, i_timestamp
// RTP out    | o_valid / i_stall       | o_out_byte, o_packet_start, o_packet_end,
//            |                         | o_packet_length, o_last_of_run
// Config     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A NAL byte inside a packet gives one output byte; a byte that opens a packet gives
// the RTP header, then the FU indicator and header (FU-A only), then the byte, sent by
// the one-byte-per-cycle output serialiser while i_stall is low. Dropped bytes and the
// first byte of a fragmented NAL give no result. The next byte is taken in the cycle the
// last result of the current one leaves. Reset is synchronous, active low; o_cfg_ready
// is always high.
module h264_rtp_fua_packetizer
    import h264fua_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH_BITS = FRAME_LENGTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_first_of_frame,
    input  logic [FRAME_LENGTH_BITS-1:0] i_frame_length,
    input  logic [31:0]                  i_timestamp,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_packet_start,
    output logic                         o_packet_end,
    output logic [10:0]                  o_packet_length,
    output logic                         o_last_of_run,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);

    localparam int unsigned FLB = FRAME_LENGTH_BITS;

    // configuration
    logic [31:0]    r_ssrc;
    logic [6:0]     r_payload_type;
    logic [10:0]    r_max_payload;

    // packetiser state
    logic [15:0]    r_seq,       n_seq;
    logic [31:0]    r_ts,        n_ts;
    logic [FLB-1:0] r_fbl,       n_fbl;
    logic [10:0]    r_pbl,       n_pbl;
    logic [7:0]     r_fu_ind,    n_fu_ind;
    logic [7:0]     r_fu_hdr,    n_fu_hdr;
    logic [10:0]    r_cur_len,   n_cur_len;

    // output run
    logic           r_busy,      n_busy;
    t_slot          r_idx,       n_idx;
    logic           r_frag,      n_frag;
    logic           r_j_marker,  n_j_marker;
    logic [15:0]    r_j_seq,     n_j_seq;
    logic [7:0]     r_j_fu_hdr,  n_j_fu_hdr;
    logic [7:0]     r_j_byte,    n_j_byte;
    logic           r_j_end,     n_j_end;

    logic           take;
    logic           accept;
    logic           run_done;
    logic [10:0]    mp;
    logic [FLB-1:0] mp_ext;
    logic [FLB:0]   fbl_plus_fu;
    logic [10:0]    len_s;
    logic [10:0]    chunk;
    logic           marker;
    logic [7:0]     fu_hdr_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc         <= SSRC_RST;
            r_payload_type <= PAYLOAD_TYPE_RST;
            r_max_payload  <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SSRC:         r_ssrc         <= i_cfg_data;
                CFG_PAYLOAD_TYPE: r_payload_type <= i_cfg_data[6:0];
                CFG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // saturate max payload to the legal range
    always_comb begin
        if (r_max_payload < MAX_PAYLOAD_MIN) begin
            mp = MAX_PAYLOAD_MIN;
        end else if (r_max_payload > MAX_PAYLOAD_MAX) begin
            mp = MAX_PAYLOAD_MAX;
        end else begin
            mp = r_max_payload;
        end
    end

    assign mp_ext      = FLB'(mp);
    assign fbl_plus_fu = (FLB+1)'(r_fbl) + (FLB+1)'(FU_BYTES);
    assign len_s       = i_frame_length[10:0];
    assign marker      = !(fbl_plus_fu > (FLB+1)'(mp));
    assign chunk       = marker ? r_fbl[10:0] : (mp - FU_BYTES);
    assign fu_hdr_out  = marker ? (r_fu_hdr | FU_END_BIT) : r_fu_hdr;

    assign take     = r_busy && !i_stall;
    assign run_done = take && (r_idx == SLOT_PAYLOAD);
    assign o_stall  = r_busy && !run_done;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_seq      = r_seq;
        n_ts       = r_ts;
        n_fbl      = r_fbl;
        n_pbl      = r_pbl;
        n_fu_ind   = r_fu_ind;
        n_fu_hdr   = r_fu_hdr;
        n_cur_len  = r_cur_len;
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_frag     = r_frag;
        n_j_marker = r_j_marker;
        n_j_seq    = r_j_seq;
        n_j_fu_hdr = r_j_fu_hdr;
        n_j_byte   = r_j_byte;
        n_j_end    = r_j_end;

        // advance the output run; skip the FU bytes on a single-NAL packet
        if (take) begin
            if (r_idx == SLOT_PAYLOAD) begin
                n_busy = 1'b0;
            end else if (r_idx == SLOT_SSRC_0 && !r_frag) begin
                n_idx = SLOT_PAYLOAD;
            end else begin
                n_idx = t_slot'(r_idx + 4'd1);
            end
        end

        if (accept) begin
            n_j_byte = i_data_byte;
            if (i_first_of_frame) begin
                n_pbl = '0;
                if (i_frame_length == '0) begin
                    n_fbl = '0;
                end else begin
                    n_ts = i_timestamp;
                    n_fbl = i_frame_length - FLB'(1);
                    if (i_frame_length > mp_ext) begin
                        // first byte only forms the FU indicator and header
                        n_fu_ind = {i_data_byte[7:5], FU_A_TYPE};
                        n_fu_hdr = FU_START_BIT | {3'b000, i_data_byte[4:0]};
                    end else begin
                        n_pbl      = len_s - 11'd1;
                        n_cur_len  = RTP_HDR_BYTES + len_s;
                        n_seq      = r_seq + 16'd1;
                        n_busy     = 1'b1;
                        n_idx      = SLOT_VERSION;
                        n_frag     = 1'b0;
                        n_j_marker = 1'b1;
                        n_j_seq    = r_seq;
                        n_j_end    = (len_s == 11'd1);
                    end
                end
            end else if (r_fbl != '0) begin
                n_fbl  = r_fbl - FLB'(1);
                n_busy = 1'b1;
                if (r_pbl == '0) begin
                    // open the next fragment
                    n_cur_len  = RTP_HDR_BYTES + FU_BYTES + chunk;
                    n_pbl      = chunk - 11'd1;
                    n_seq      = r_seq + 16'd1;
                    n_idx      = SLOT_VERSION;
                    n_frag     = 1'b1;
                    n_j_marker = marker;
                    n_j_seq    = r_seq;
                    n_j_fu_hdr = fu_hdr_out;
                    n_fu_hdr   = fu_hdr_out & FU_KEEP_MASK;
                    n_j_end    = (chunk == 11'd1);
                end else begin
                    n_pbl   = r_pbl - 11'd1;
                    n_idx   = SLOT_PAYLOAD;
                    n_j_end = (r_pbl == 11'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= '0;
            r_ts      <= '0;
            r_fbl     <= '0;
            r_pbl     <= '0;
            r_fu_ind  <= '0;
            r_fu_hdr  <= '0;
            r_cur_len <= '0;
            r_busy    <= 1'b0;
            r_idx     <= SLOT_VERSION;
        end else begin
            r_seq     <= n_seq;
            r_ts      <= n_ts;
            r_fbl     <= n_fbl;
            r_pbl     <= n_pbl;
            r_fu_ind  <= n_fu_ind;
            r_fu_hdr  <= n_fu_hdr;
            r_cur_len <= n_cur_len;
            r_busy    <= n_busy;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frag     <= n_frag;
        r_j_marker <= n_j_marker;
        r_j_seq    <= n_j_seq;
        r_j_fu_hdr <= n_j_fu_hdr;
        r_j_byte   <= n_j_byte;
        r_j_end    <= n_j_end;
    end

    // timestamp, FU indicator and length hold until the run's last byte leaves; ssrc is read live
    always_comb begin
        o_packet_start = 1'b0;
        o_packet_end   = 1'b0;
        o_last_of_run  = 1'b0;
        case (r_idx)
            SLOT_VERSION: begin
                o_out_byte     = RTP_VERSION_BYTE;
                o_packet_start = 1'b1;
            end
            SLOT_MARK_PT: o_out_byte = {r_j_marker, r_payload_type};
            SLOT_SEQ_HI:  o_out_byte = r_j_seq[15:8];
            SLOT_SEQ_LO:  o_out_byte = r_j_seq[7:0];
            SLOT_TS_3:    o_out_byte = r_ts[31:24];
            SLOT_TS_2:    o_out_byte = r_ts[23:16];
            SLOT_TS_1:    o_out_byte = r_ts[15:8];
            SLOT_TS_0:    o_out_byte = r_ts[7:0];
            SLOT_SSRC_3:  o_out_byte = r_ssrc[31:24];
            SLOT_SSRC_2:  o_out_byte = r_ssrc[23:16];
            SLOT_SSRC_1:  o_out_byte = r_ssrc[15:8];
            SLOT_SSRC_0:  o_out_byte = r_ssrc[7:0];
            SLOT_FU_IND:  o_out_byte = r_fu_ind;
            SLOT_FU_HDR:  o_out_byte = r_j_fu_hdr;
            SLOT_PAYLOAD: begin
                o_out_byte    = r_j_byte;
                o_packet_end  = r_j_end;
                o_last_of_run = 1'b1;
            end
            default:      o_out_byte = r_j_byte;
        endcase
    end

    assign o_valid         = r_busy;
    assign o_packet_length = r_cur_len;

endmodule

FILE: tb/h264_rtp_fua_checker.sv
module h264_rtp_fua_checker
    import h264fua_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH_BITS = FRAME_LENGTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_nal_valid,
    input  logic                         i_nal_stall,
    input  logic [7:0]                   i_nal_byte,
    input  logic                         i_nal_first,
    input  logic [FRAME_LENGTH_BITS-1:0] i_nal_length,
    input  logic [31:0]                  i_nal_timestamp,

    input  logic                         i_rtp_valid,
    input  logic                         i_rtp_stall,
    input  logic [7:0]                   i_rtp_byte,
    input  logic                         i_rtp_start,
    input  logic                         i_rtp_end,
    input  logic [10:0]                  i_rtp_length,
    input  logic                         i_rtp_last,

    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [31:0]                  i_cfg_data,

    output int                           o_mismatches,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]  octet;
        logic        opens;
        logic        closes;
        logic [10:0] length;
        logic        run_end;
    } t_rtp_octet;

    t_rtp_octet octets_due[$];
    t_rtp_octet due;
    t_rtp_octet seen;
    int         mismatches = 0;

    logic [31:0]                  reg_ssrc;
    logic [6:0]                   reg_payload_type;
    logic [10:0]                  reg_max_payload;

    logic [15:0]                  seq_num;
    logic [31:0]                  nal_ts;
    logic [FRAME_LENGTH_BITS-1:0] nal_left;
    logic [10:0]                  pkt_left;
    logic [10:0]                  pkt_len;
    logic [7:0]                   fu_ind;
    logic [7:0]                   fu_hdr;

    assign o_mismatches = mismatches;

    task automatic push_octet(input logic [7:0] value, input logic opens, input logic closes,
                              input logic run_end);
        t_rtp_octet entry;
        entry.octet   = value;
        entry.opens   = opens;
        entry.closes  = closes;
        entry.length  = pkt_len;
        entry.run_end = run_end;
        octets_due.push_back(entry);
    endtask

    task automatic push_rtp_header(input logic marker);
        push_octet(RTP_VERSION_BYTE, 1'b1, 1'b0, 1'b0);
        push_octet({marker, reg_payload_type}, 1'b0, 1'b0, 1'b0);
        push_octet(seq_num[15:8], 1'b0, 1'b0, 1'b0);
        push_octet(seq_num[7:0], 1'b0, 1'b0, 1'b0);
        for (int i = 3; i >= 0; i--)
            push_octet(nal_ts[8*i +: 8], 1'b0, 1'b0, 1'b0);
        for (int i = 3; i >= 0; i--)
            push_octet(reg_ssrc[8*i +: 8], 1'b0, 1'b0, 1'b0);
        seq_num = seq_num + 16'd1;
    endtask

    task automatic predict_nal_byte(input logic [7:0] b, input logic first,
                                    input logic [FRAME_LENGTH_BITS-1:0] len,
                                    input logic [31:0] stamp);
        logic [10:0] mp;
        logic [10:0] chunk;
        logic        marker;
        // payload limit saturates, read afresh for every packet
        if (reg_max_payload < MAX_PAYLOAD_MIN)
            mp = MAX_PAYLOAD_MIN;
        else if (reg_max_payload > MAX_PAYLOAD_MAX)
            mp = MAX_PAYLOAD_MAX;
        else
            mp = reg_max_payload;

        if (first) begin
            // a new NAL abandons whatever was in flight
            pkt_left = '0;
            if (len == '0) begin
                nal_left = '0;
                return;
            end
            nal_ts = stamp;
            if (32'(len) > 32'(mp)) begin
                // header byte is folded into the FU-A indicator and header
                fu_ind   = {b[7:5], FU_A_TYPE};
                fu_hdr   = FU_START_BIT | {3'b000, b[4:0]};
                nal_left = len - 1'b1;
                return;
            end
            nal_left = len;
            pkt_left = len[10:0];
            pkt_len  = RTP_HDR_BYTES + len[10:0];
            push_rtp_header(1'b1);
        end else begin
            if (nal_left == '0)
                return;
            if (pkt_left == '0) begin
                if (32'(nal_left) + 32'd2 > 32'(mp)) begin
                    chunk  = mp - FU_BYTES;
                    marker = 1'b0;
                end else begin
                    chunk  = nal_left[10:0];
                    marker = 1'b1;
                    fu_hdr = fu_hdr | FU_END_BIT;
                end
                pkt_len  = RTP_HDR_BYTES + FU_BYTES + chunk;
                pkt_left = chunk;
                push_rtp_header(marker);
                push_octet(fu_ind, 1'b0, 1'b0, 1'b0);
                push_octet(fu_hdr, 1'b0, 1'b0, 1'b0);
                fu_hdr = fu_hdr & FU_KEEP_MASK;
            end
        end

        pkt_left = pkt_left - 11'd1;
        nal_left = nal_left - 1'b1;
        push_octet(b, 1'b0, pkt_left == '0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_ssrc         = SSRC_RST;
            reg_payload_type = PAYLOAD_TYPE_RST;
            reg_max_payload  = MAX_PAYLOAD_RST;
            seq_num          = '0;
            nal_ts           = '0;
            nal_left         = '0;
            pkt_left         = '0;
            pkt_len          = '0;
            fu_ind           = '0;
            fu_hdr           = '0;
            octets_due.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    CFG_SSRC:         reg_ssrc         = i_cfg_data;
                    CFG_PAYLOAD_TYPE: reg_payload_type = i_cfg_data[6:0];
                    CFG_MAX_PAYLOAD:  reg_max_payload  = i_cfg_data[10:0];
                    default: ;
                endcase
            end

            // predict before comparing so that an empty queue is never popped early
            if (i_nal_valid === 1'b1 && i_nal_stall === 1'b0)
                predict_nal_byte(i_nal_byte, i_nal_first, i_nal_length, i_nal_timestamp);

            if (i_rtp_valid === 1'b1 && i_rtp_stall === 1'b0) begin
                seen.octet   = i_rtp_byte;
                seen.opens   = i_rtp_start;
                seen.closes  = i_rtp_end;
                seen.length  = i_rtp_length;
                seen.run_end = i_rtp_last;
                if (octets_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: unexpected item: byte %02h start %0b end %0b",
                                  " len %0d last %0b"},
                                 $time, seen.octet, seen.opens, seen.closes, seen.length,
                                 seen.run_end);
                end else begin
                    due = octets_due.pop_front();
                    if (seen !== due) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display({"%0t: mismatch: expected byte %02h start %0b end %0b",
                                      " len %0d last %0b"},
                                     $time, due.octet, due.opens, due.closes, due.length,
                                     due.run_end);
                            $display({"%0t:           got      byte %02h start %0b end %0b",
                                      " len %0d last %0b"},
                                     $time, seen.octet, seen.opens, seen.closes, seen.length,
                                     seen.run_end);
                        end
                    end
                end
            end
        end
        o_pending <= octets_due.size();
    end

endmodule

FILE: tb/tb_h264_rtp_fua_packetizer.sv
module tb_h264_rtp_fua_packetizer;
    timeunit 1ns;
    timeprecision 1ps;

    import h264fua_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int ITEMS_PER_PHASE = 44;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef logic [FRAME_LENGTH_BITS_DEF-1:0] t_nal_length;

    localparam t_nal_length MAX_NAL_LENGTH = '1;

    logic        i_clk;
    logic        i_rst_n;

    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_first_of_frame;
    t_nal_length i_frame_length;
    logic [31:0] i_timestamp;

    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_packet_start;
    logic        o_packet_end;
    logic [10:0] o_packet_length;
    logic        o_last_of_run;

    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int eff_payload = int'(MAX_PAYLOAD_RST);
    bit calm_in     = 1'b0;
    bit calm_out    = 1'b0;

    h264_rtp_fua_packetizer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_frame_length   (i_frame_length),
        .i_timestamp      (i_timestamp),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_packet_start   (o_packet_start),
        .o_packet_end     (o_packet_end),
        .o_packet_length  (o_packet_length),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    h264_rtp_fua_checker rtp_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nal_valid     (i_valid),
        .i_nal_stall     (o_stall),
        .i_nal_byte      (i_data_byte),
        .i_nal_first     (i_first_of_frame),
        .i_nal_length    (i_frame_length),
        .i_nal_timestamp (i_timestamp),
        .i_rtp_valid     (o_valid),
        .i_rtp_stall     (i_stall),
        .i_rtp_byte      (o_out_byte),
        .i_rtp_start     (o_packet_start),
        .i_rtp_end       (o_packet_end),
        .i_rtp_length    (o_packet_length),
        .i_rtp_last      (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_idle(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input t_nal_length len,
                             input logic [31:0] stamp);
        int gap;
        if ($urandom_range(0, 23) == 0)
            calm_in = !calm_in;
        gap = draw_idle(calm_in);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_first_of_frame <= first;
        i_frame_length   <= len;
        i_timestamp      <= stamp;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic send_nal(input logic [7:0] head, input t_nal_length len,
                            input logic [31:0] stamp, input int n_bytes);
        send_byte(head, 1'b1, len, stamp);
        repeat (n_bytes - 1)
            send_byte(8'($urandom), 1'b0, t_nal_length'($urandom), $urandom);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
    endtask

    // hold input off until every expected item has left, then let the block go quiet
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] ssrc, input logic [6:0] pt,
                             input logic [10:0] max_payload);
        logic [31:0] word;
        settle();
        write_reg(CFG_SSRC, ssrc);
        // upper bits are junk the block must ignore
        word      = $urandom;
        word[6:0] = pt;
        write_reg(CFG_PAYLOAD_TYPE, word);
        word       = $urandom;
        word[10:0] = max_payload;
        write_reg(CFG_MAX_PAYLOAD, word);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
        if (max_payload < MAX_PAYLOAD_MIN)
            eff_payload = int'(MAX_PAYLOAD_MIN);
        else if (max_payload > MAX_PAYLOAD_MAX)
            eff_payload = int'(MAX_PAYLOAD_MAX);
        else
            eff_payload = int'(max_payload);
    endtask

    task automatic random_nal(output int counted);
        int          pick;
        int          extra;
        t_nal_length len;
        pick    = $urandom_range(0, 99);
        counted = 0;
        extra   = 0;
        len     = '0;
        if (pick < 70) begin
            // complete NAL, long enough to fragment when the payload limit is small
            if (eff_payload <= 64)
                len = t_nal_length'($urandom_range(1, 2 * eff_payload + 4));
            else
                len = t_nal_length'($urandom_range(1, 24));
            counted = int'(len);
        end else if (pick < 85) begin
            // long or boundary NAL, cut short by whatever comes next
            case ($urandom_range(0, 3))
                0:       len = t_nal_length'(eff_payload);
                1:       len = t_nal_length'(eff_payload + 1);
                2:       len = MAX_NAL_LENGTH;
                default: len = t_nal_length'($urandom_range(1, 4000));
            endcase
            counted = $urandom_range(1, 5);
            if (counted > int'(len))
                counted = int'(len);
        end else if (pick < 92) begin
            extra = $urandom_range(1, 3);
        end else if (pick < 96) begin
            send_byte(8'($urandom), 1'b1, '0, $urandom);
        end else begin
            len     = t_nal_length'($urandom_range(1, 8));
            counted = int'(len);
            extra   = $urandom_range(1, 3);
        end
        if (counted > 0)
            send_nal(8'($urandom), len, $urandom, counted);
        repeat (extra)
            send_byte(8'($urandom), 1'b0, t_nal_length'($urandom), $urandom);
    endtask

    task automatic run_random_phase();
        int sent;
        int n;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            random_nal(n);
            sent += n;
        end
    endtask

    // output side: draw a stall before every item
    initial begin
        int hold;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 23) == 0)
                calm_out = !calm_out;
            hold = draw_idle(calm_out);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= '0;
        i_first_of_frame <= 1'b0;
        i_frame_length   <= '0;
        i_timestamp      <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_SSRC;
        i_cfg_data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: drops, boundaries and abandoned NALs
        send_byte(8'hA5, 1'b0, t_nal_length'(20'h12345), 32'h0);
        send_byte(8'h5A, 1'b1, '0, 32'hFFFF_FFFF);
        send_nal(8'hFF, t_nal_length'(1), 32'hFFFF_FFFF, 1);
        send_nal(8'h00, t_nal_length'(3), 32'h0, 3);
        send_byte(8'h3C, 1'b0, MAX_NAL_LENGTH, 32'hFFFF_FFFF);
        send_nal(8'hFF, MAX_NAL_LENGTH, 32'h89AB_CDEF, 3);
        send_nal(8'h65, t_nal_length'(5), $urandom, 2);
        send_nal(8'h41, t_nal_length'(2), $urandom, 2);
        send_nal(8'h67, t_nal_length'(MAX_PAYLOAD_RST), $urandom, 2);
        send_byte(8'h00, 1'b1, '0, 32'h0);
        send_nal(8'h1F, t_nal_length'(MAX_PAYLOAD_RST + 1), $urandom, 2);

        configure(32'hFFFF_FFFF, 7'd127, MAX_PAYLOAD_MIN);
        run_random_phase();
        configure(32'h0, 7'd0, MAX_PAYLOAD_MIN + 11'd1);
        run_random_phase();
        configure($urandom, 7'($urandom), MAX_PAYLOAD_MAX);
        run_random_phase();
        // out-of-range limits saturate
        configure($urandom, 7'($urandom), 11'h7FF);
        run_random_phase();
        configure($urandom, 7'($urandom), 11'd0);
        run_random_phase();
        configure($urandom, 7'($urandom), 11'($urandom_range(18, 48)));
        run_random_phase();

        settle();
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
